// File: hdl/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash core.
// No dependencies; imported by every module under hdl/.
package sha1_pkg;

  localparam int unsigned NUM_WORDS = 5;

  typedef logic [31:0] word_t;
  typedef logic [NUM_WORDS-1:0][31:0] digest_t;

  // Chaining value after reset, word 0 in the lowest slot
  localparam digest_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

  localparam word_t K_0 = 32'h5A827999;
  localparam word_t K_1 = 32'h6ED9EBA1;
  localparam word_t K_2 = 32'h8F1BBCDC;
  localparam word_t K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_INDEX = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Head of the command queue as seen by the engine
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } fq_t;

  typedef enum logic [2:0] {
    ST_ABSORB,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_DIGEST
  } eng_state_e;

endpackage

// File: hdl/sha1_hash_core.sv
// SHA-1 hash core. Message bytes stream in one per push; the push marked
// is_last (with or without a byte) closes the message, and five digest words
// then come out, word 0 first. Pushes land in a FifoDepth-entry command
// queue, so the input keeps taking items while the engine compresses. The
// engine absorbs one byte per cycle while the queue holds one and it is not
// compressing, padding or handing off a digest. Each 64-byte block takes 80
// rounds on one shared round unit, plus the chaining update. Closing adds
// 9 to 72 padding and length bytes and one or two blocks. The digest sits
// in its own output stage; the next message may start before it is read.
module sha1_hash_core import sha1_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  in_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t out_item_o
);

  fq_t     fq;
  logic    fq_pop;
  logic    out_ready;
  logic    out_load;
  digest_t digest;

  sha1_front #(
    .Depth (FifoDepth)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .item_i (in_item_i),
    .full_o (full_o),
    .fq_o   (fq),
    .pop_i  (fq_pop)
  );

  sha1_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fq_i        (fq),
    .fq_pop_o    (fq_pop),
    .out_ready_i (out_ready),
    .out_load_o  (out_load),
    .digest_o    (digest)
  );

  sha1_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (out_load),
    .digest_i   (digest),
    .ready_o    (out_ready),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_item_o (out_item_o)
  );

endmodule

// File: hdl/sha1_front.sv
// Front end of the SHA-1 core: input handshake and command queue.
// Items that carry neither a byte nor an end mark are dropped here.
// Depends on sha1_pkg.
module sha1_front import sha1_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  output fq_t      fq_o,
  input  logic     pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  in_item_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                keep, wr_en, rd_en;

  assign full_o = (cnt_q == CntW'(Depth));
  assign keep   = item_i.has_byte | item_i.is_last;
  assign wr_en  = push_i & ~full_o & keep;
  assign rd_en  = pop_i & (cnt_q != '0);

  assign fq_o.valid = (cnt_q != '0);
  assign fq_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: hdl/sha1_engine.sv
// Back end of the SHA-1 core: byte packing, padding, 80-round compression.
// Takes commands from sha1_front and hands digests to sha1_out.
// Depends on sha1_pkg.
module sha1_engine import sha1_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  fq_t     fq_i,
  output logic    fq_pop_o,
  input  logic    out_ready_i,
  output logic    out_load_o,
  output digest_t digest_o
);

  eng_state_e    state_q, state_d;
  logic [5:0]    pos_q, pos_d;
  logic [60:0]   cnt_q, cnt_d;
  logic [63:0]   len_q, len_d;
  logic [23:0]   acc_q, acc_d;
  word_t         blk_q [16];
  word_t         blk_d [16];
  digest_t       h_q, h_d;
  word_t         v_q [5];
  word_t         v_d [5];
  logic [6:0]    rnd_q, rnd_d;
  logic          pad_first_q, pad_first_d;
  logic          wrap_q, wrap_d;
  logic          pad_pend_q, pad_pend_d;
  logic          final_q, final_d;

  logic          take_byte;
  logic [7:0]    byte_val;
  logic          len_byte;
  word_t         w_new, w_r, f_r, k_r, t_r;

  // Message schedule from a 16-word sliding window
  assign w_new = blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0];
  assign w_r   = (rnd_q < 7'd16) ? blk_q[0] : {w_new[30:0], w_new[31]};

  always_comb begin
    if (rnd_q < 7'd20) begin
      f_r = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
      k_r = K_0;
    end else if (rnd_q < 7'd40) begin
      f_r = v_q[1] ^ v_q[2] ^ v_q[3];
      k_r = K_1;
    end else if (rnd_q < 7'd60) begin
      f_r = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
      k_r = K_2;
    end else begin
      f_r = v_q[1] ^ v_q[2] ^ v_q[3];
      k_r = K_3;
    end
  end

  assign t_r = {v_q[0][26:0], v_q[0][31:27]} + f_r + v_q[4] + k_r + w_r;

  assign digest_o = h_q;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    acc_d       = acc_q;
    blk_d       = blk_q;
    h_d         = h_q;
    v_d         = v_q;
    rnd_d       = rnd_q;
    pad_first_d = pad_first_q;
    wrap_d      = wrap_q;
    pad_pend_d  = pad_pend_q;
    final_d     = final_q;
    fq_pop_o    = 1'b0;
    out_load_o  = 1'b0;
    take_byte   = 1'b0;
    byte_val    = '0;
    len_byte    = 1'b0;

    unique case (state_q)
      ST_ABSORB: begin
        if (fq_i.valid) begin
          fq_pop_o = 1'b1;
          if (fq_i.item.has_byte) begin
            take_byte = 1'b1;
            byte_val  = fq_i.item.data_byte;
            cnt_d     = cnt_q + 61'd1;
            if (pos_q == 6'd63) begin
              state_d    = ST_ROUND;
              pad_pend_d = fq_i.item.is_last;
            end else if (fq_i.item.is_last) begin
              state_d     = ST_PAD;
              pad_first_d = 1'b1;
            end
          end else begin
            state_d     = ST_PAD;
            pad_first_d = 1'b1;
          end
        end
      end
      ST_PAD: begin
        take_byte = 1'b1;
        if (pad_first_q) begin
          // end marker; if it lands in the last eight bytes, the length
          // goes in a further block
          byte_val    = PAD_BYTE;
          pad_first_d = 1'b0;
          wrap_d      = (pos_q[5:3] == 3'd7);
          len_d       = {cnt_q, 3'b000};
          cnt_d       = '0;
        end else if (pos_q[5:3] == 3'd7 && !wrap_q) begin
          byte_val = len_q[63:56];
          len_d    = {len_q[55:0], 8'h00};
          len_byte = 1'b1;
        end
        if (pos_q == 6'd63) begin
          final_d = len_byte;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          blk_d[i] = blk_q[i+1];
        end
        blk_d[15] = w_r;
        v_d[4] = v_q[3];
        v_d[3] = v_q[2];
        v_d[2] = {v_q[1][1:0], v_q[1][31:2]};
        v_d[1] = v_q[0];
        v_d[0] = t_r;
        rnd_d  = rnd_q + 7'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        for (int i = 0; i < 5; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        if (pad_pend_q) begin
          pad_pend_d  = 1'b0;
          pad_first_d = 1'b1;
          state_d     = ST_PAD;
        end else if (final_q) begin
          final_d = 1'b0;
          state_d = ST_DIGEST;
        end else if (wrap_q) begin
          // zero fill and length in a block of their own
          wrap_d  = 1'b0;
          state_d = ST_PAD;
        end else begin
          state_d = ST_ABSORB;
        end
      end
      ST_DIGEST: begin
        if (out_ready_i) begin
          out_load_o = 1'b1;
          h_d        = H_INIT;
          state_d    = ST_ABSORB;
        end
      end
      default: begin
        state_d = ST_ABSORB;
      end
    endcase

    // Byte path, shared by message and padding bytes
    if (take_byte) begin
      pos_d = pos_q + 6'd1;
      if (pos_q[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          blk_d[i] = blk_q[i+1];
        end
        blk_d[15] = {acc_q, byte_val};
      end else begin
        acc_d = {acc_q[15:0], byte_val};
      end
      if (pos_q == 6'd63) begin
        rnd_d = '0;
        for (int i = 0; i < 5; i++) begin
          v_d[i] = h_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ABSORB;
      pos_q       <= '0;
      cnt_q       <= '0;
      h_q         <= H_INIT;
      rnd_q       <= '0;
      pad_first_q <= 1'b0;
      wrap_q      <= 1'b0;
      pad_pend_q  <= 1'b0;
      final_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      h_q         <= h_d;
      rnd_q       <= rnd_d;
      pad_first_q <= pad_first_d;
      wrap_q      <= wrap_d;
      pad_pend_q  <= pad_pend_d;
      final_q     <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    acc_q <= acc_d;
    blk_q <= blk_d;
    v_q   <= v_d;
  end

  // Compression only ever starts on a block boundary
  a_round_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (pos_q == 6'd0))
    else $error("round running with a partial block");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (rnd_q <= LAST_ROUND))
    else $error("round counter out of range");

  a_digest_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGEST) |-> (cnt_q == '0 && pos_q == 6'd0 && !pad_pend_q))
    else $error("digest reached with message state left over");

  a_load_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |=> (h_q == H_INIT && state_q == ST_ABSORB))
    else $error("chaining value not reinitialised after digest");

endmodule

// File: hdl/sha1_out.sv
// Result stage of the SHA-1 core: holds one digest and presents it word
// by word on a queue-style read port. Depends on sha1_pkg.
module sha1_out import sha1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  digest_t   digest_i,
  output logic      ready_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  word_t      words_q [NUM_WORDS];
  logic [2:0] idx_q;
  logic       busy_q;

  assign ready_o = ~busy_q;
  assign empty_o = ~busy_q;

  assign out_item_o.digest_word = words_q[idx_q];
  assign out_item_o.word_index  = idx_q;
  assign out_item_o.last_word   = (idx_q == LAST_INDEX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i && !busy_q) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (pop_i && busy_q) begin
      if (idx_q == LAST_INDEX) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && !busy_q) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_q[i] <= digest_i[i];
      end
    end
  end

endmodule

// File: verif/sha1_hash_core_tb.sv
// Self-checking testbench for sha1_hash_core: streams byte messages through the
// push/full side and checks every digest word popped off the result side.
// Depends on sha1_pkg (item structs) and the core RTL only.
`timescale 1ns / 1ps

module sha1_hash_core_tb;
  import sha1_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // Round constants, one per group of twenty rounds
  localparam logic [31:0] RK_CH  = 32'h5A827999;
  localparam logic [31:0] RK_P1  = 32'h6ED9EBA1;
  localparam logic [31:0] RK_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] RK_P2  = 32'hCA62C1D6;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push   = 1'b0;
  in_item_t  in_item = '0;
  logic      pop    = 1'b0;
  logic      full_o;
  logic      empty_o;
  out_item_t out_item_o;

  sha1_hash_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_item),
    .full_o     (full_o),
    .pop_i      (pop),
    .empty_o    (empty_o),
    .out_item_o (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state
  logic [31:0] chain_h [5];
  logic [31:0] msg_blk [16];
  logic [60:0] msg_len;

  in_item_t  msg_items_q [$];
  out_item_t digest_words_q [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_len      = 0;
  int mismatches    = 0;
  int items_queued  = 0;
  int cycles        = 0;

  function automatic void restart_chain();
    chain_h[0] = 32'h67452301;
    chain_h[1] = 32'hEFCDAB89;
    chain_h[2] = 32'h98BADCFE;
    chain_h[3] = 32'h10325476;
    chain_h[4] = 32'hC3D2E1F0;
    msg_len    = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, k, wr, t;
    for (int i = 0; i < 16; i++) sched[i] = msg_blk[i];
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = sched[r];
      end else begin
        wr = sched[(r - 3) % 16] ^ sched[(r - 8) % 16] ^ sched[(r - 14) % 16] ^ sched[r % 16];
        wr = {wr[30:0], wr[31]};
        sched[r % 16] = wr;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RK_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RK_P1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RK_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = RK_P2;
      end
      t = {a[26:0], a[31:27]} + f + e + k + wr;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Absorbs one accepted item; a closing item queues the five digest words
  function automatic void hash_item(in_item_t it);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    out_item_t   o;
    int          wi, bi;
    if (it.has_byte) begin
      pos = msg_len[5:0];
      wi  = pos[5:2];
      bi  = pos[1:0];
      msg_blk[wi][8 * (3 - bi) +: 8] = it.data_byte;
      msg_len = msg_len + 61'd1;
      if (pos == 6'd63) compress_block();
    end
    if (!it.is_last) return;
    pos = msg_len[5:0];
    wi  = pos[5:2];
    bi  = pos[1:0];
    msg_blk[wi][8 * (3 - bi) +: 8] = 8'h80;
    for (int j = bi + 1; j < 4; j++) msg_blk[wi][8 * (3 - j) +: 8] = 8'h00;
    for (int i = wi + 1; i < 16; i++) msg_blk[i] = '0;
    // no room for the length: it goes into an extra block of its own
    if (pos >= 6'd56) begin
      compress_block();
      for (int i = 0; i < 16; i++) msg_blk[i] = '0;
    end
    bit_len = {msg_len, 3'b000};
    msg_blk[14] = bit_len[63:32];
    msg_blk[15] = bit_len[31:0];
    compress_block();
    for (int i = 0; i < 5; i++) begin
      o.digest_word = chain_h[i];
      o.word_index  = 3'(i);
      o.last_word   = (i == 4);
      digest_words_q.push_back(o);
    end
    restart_chain();
  endfunction

  // Driver: offer the head of the queue, take it off on a transfer
  always @(negedge clk_i) begin
    if (rst_ni && msg_items_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      push    <= 1'b1;
      in_item <= msg_items_q[0];
    end else begin
      push    <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && !full_o) begin
      hash_item(in_item);
      void'(msg_items_q.pop_front());
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here
  int held = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (held < hold_len) begin
      pop  <= 1'b0;
      held <= held + 1;
    end else begin
      pop  <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    out_item_t exp_w;
    if (rst_ni && pop && !empty_o) begin
      if (digest_words_q.size() == 0) begin
        $error("unexpected digest word %h (index %0d)", out_item_o.digest_word,
               out_item_o.word_index);
        mismatches++;
      end else begin
        exp_w = digest_words_q.pop_front();
        if (out_item_o.digest_word !== exp_w.digest_word) begin
          $error("digest_word: expected %h, got %h", exp_w.digest_word,
                 out_item_o.digest_word);
          mismatches++;
        end
        if (out_item_o.word_index !== exp_w.word_index) begin
          $error("word_index: expected %0d, got %0d", exp_w.word_index,
                 out_item_o.word_index);
          mismatches++;
        end
        if (out_item_o.last_word !== exp_w.last_word) begin
          $error("last_word: expected %0b, got %0b", exp_w.last_word,
                 out_item_o.last_word);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_item(input logic [7:0] data, input logic has, input logic last);
    in_item_t it;
    it.data_byte = data;
    it.has_byte  = has;
    it.is_last   = last;
    msg_items_q.push_back(it);
    items_queued++;
  endtask

  // One message of random bytes, odd noise items mixed in; the close either
  // rides on the final byte or comes as an item of its own
  task automatic add_message(input int nbytes, input bit join_last);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(19) == 0) add_item(8'($urandom_range(255)), 1'b0, 1'b0);
      add_item(8'($urandom_range(255)), 1'b1, join_last && (i == nbytes - 1));
    end
    if (!join_last || nbytes == 0) add_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (msg_items_q.size() != 0 || digest_words_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
    int start, sel, len, room;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    start = items_queued;
    while (items_queued - start < n_items) begin
      room = n_items - (items_queued - start);
      sel = $urandom_range(99);
      if (sel < 70)      len = $urandom_range(10);
      else if (sel < 90) len = $urandom_range(66, 52);  // around the padding split
      else               len = $urandom_range(130, 118);
      // keep the phase near its item budget
      if (len > room - 1) len = room - 1;
      add_message(len, $urandom_range(1));
    end
    wait_drained();
  endtask

  initial begin
    restart_chain();
    for (int i = 0; i < 16; i++) msg_blk[i] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty message, byte with close, separate close, noise, extremes
    add_item(8'hFF, 1'b0, 1'b1);
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'h63, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b0, 1'b0);
    add_item(8'hA5, 1'b0, 1'b1);
    add_item(8'hFF, 1'b1, 1'b1);
    add_item(8'hFF, 1'b0, 1'b0);
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'h7F, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    // close near the end of a block, either side of the length split
    add_message($urandom_range(64, 55), $urandom_range(1));
    wait_drained();

    // Receiver holds off while short messages keep arriving, so the input backs up
    hold_len = 600;
    for (int m = 0; m < 8; m++) add_message($urandom_range(6), $urandom_range(1));
    wait_drained();

    run_phase(0, 0, 25);
    run_phase(63, 0, 25);
    run_phase(0, 63, 25);
    run_phase(15, 15, 25);

    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && digest_words_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/sha1_pkg.sv
hdl/sha1_front.sv
hdl/sha1_engine.sv
hdl/sha1_out.sv
hdl/sha1_hash_core.sv
verif/sha1_hash_core_tb.sv
